@@ rtl/core/fcba_pkg.sv @@
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared types, constants and helpers of the chained block allocator: block
// and count widths, command and status codes, and the reset link of an entry.
// ----------------------------------------------------------------------------
package fcba_pkg;

	// Table geometry
	localparam int unsigned NUM_BLOCKS = 256;
	localparam int unsigned BLK_W      = 8;
	localparam int unsigned CNT_W      = 9;
	localparam int unsigned ADDR_W     = $clog2(NUM_BLOCKS);

	typedef logic [BLK_W-1:0]  blk_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Command codes
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_NEXT  = 2'd2,
		CMD_LINK  = 2'd3
	} cmd_t;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Link table write request
	typedef struct packed {
		logic  en;
		addr_t addr;
		blk_t  data;
	} wr_req_t;

	// Result of one command
	typedef struct packed {
		logic [1:0] status;
		blk_t       block_out;
		logic       end_of_chain;
	} result_t;

	// Link held by an entry that was never written: next block, last one self
	function automatic blk_t reset_link(addr_t a);
		cnt_t nxt;
		nxt = cnt_t'(a) + cnt_t'(1);
		if (nxt < cnt_t'(NUM_BLOCKS)) begin
			reset_link = blk_t'(nxt);
		end else begin
			reset_link = blk_t'(a);
		end
	endfunction

	// Block number lies inside the table
	function automatic logic in_range(blk_t b);
		in_range = cnt_t'(b) < cnt_t'(NUM_BLOCKS);
	endfunction

endpackage

@@ rtl/core/fat_chain_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// Link table block allocator: chains of blocks end in a self link, free blocks
// form a list with a head and a count. Allocate, free, next and link commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   start & !busy             cmd, block, link_to
//  result    done (one cycle strobe)   status, block_out, end_of_chain,
//                                      free_count
//
//  Each command is accepted at an edge that reads the link table into the
//  registered read port; in S_EXEC the command unit runs, and the edge leaving
//  it writes the table and registers the beat: one read and one write per
//  command. busy is high for the one cycle between them; done follows with
//  busy low, so a new command may be started in the cycle its result is shown.
//  Reset leaves every block free with head 0, and is ready at once.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             cmd,
	input  fcba_pkg::blk_t         block,
	input  fcba_pkg::blk_t         link_to,
	output logic                   done,
	output logic [1:0]             status,
	output fcba_pkg::blk_t         block_out,
	output logic                   end_of_chain,
	output fcba_pkg::cnt_t         free_count
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t            state_q;
	fcba_pkg::cmd_t    cmd_q;
	fcba_pkg::blk_t    block_q;
	fcba_pkg::blk_t    link_to_q;
	fcba_pkg::addr_t   head_q;
	fcba_pkg::cnt_t    count_q;
	logic              done_q;
	fcba_pkg::result_t res_q;

	logic              accept;
	fcba_pkg::addr_t   rd_addr;
	fcba_pkg::blk_t    link;
	fcba_pkg::wr_req_t wr;
	fcba_pkg::wr_req_t wr_mem;
	fcba_pkg::addr_t   head_nxt;
	fcba_pkg::cnt_t    count_nxt;
	fcba_pkg::result_t res;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Allocate reads the head's link, the other commands the block's
	assign rd_addr = (fcba_pkg::cmd_t'(cmd) == fcba_pkg::CMD_ALLOC) ?
		head_q : fcba_pkg::addr_t'(block);

	// Let the table write through only in the execute cycle
	always_comb begin
		wr_mem    = wr;
		wr_mem.en = wr.en && (state_q == S_EXEC);
	end

	fcba_link_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (link),
		.wr      (wr_mem)
	);

	fcba_exec u_exec (
		.cmd       (cmd_q),
		.block     (block_q),
		.link_to   (link_to_q),
		.head      (head_q),
		.count     (count_q),
		.link      (link),
		.wr        (wr),
		.head_nxt  (head_nxt),
		.count_nxt (count_nxt),
		.res       (res)
	);

	// Hold the command payload while it executes
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= fcba_pkg::cmd_t'(cmd);
			block_q   <= block;
			link_to_q <= link_to;
		end
	end

	// Sequence the command, update the free list, register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= fcba_pkg::cnt_t'(fcba_pkg::NUM_BLOCKS);
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					head_q  <= head_nxt;
					count_q <= count_nxt;
					res_q   <= res;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = res_q.status;
	assign block_out    = res_q.block_out;
	assign end_of_chain = res_q.end_of_chain;
	assign free_count   = count_q;

endmodule

@@ rtl/core/fcba_link_mem.sv @@
// ----------------------------------------------------------------------------
// fcba_link_mem
// Link table memory: one write port, one registered read port. A valid bit
// per entry, cleared at reset, makes an unwritten entry read as its reset link.
// ----------------------------------------------------------------------------
module fcba_link_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  fcba_pkg::addr_t  rd_addr,
	output fcba_pkg::blk_t   rd_data,
	input  fcba_pkg::wr_req_t wr
);

	fcba_pkg::blk_t  mem [fcba_pkg::NUM_BLOCKS];
	logic [fcba_pkg::NUM_BLOCKS-1:0] vld_q;
	fcba_pkg::blk_t  rd_q;
	logic            rd_vld_q;
	fcba_pkg::addr_t rd_addr_q;

	// Store array: write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Valid bits: clear at reset, set on write, sample with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Substitute the reset link for an entry never written
	assign rd_data = rd_vld_q ? rd_q : fcba_pkg::reset_link(rd_addr_q);

endmodule

@@ rtl/core/fcba_exec.sv @@
// ----------------------------------------------------------------------------
// fcba_exec
// Command unit: from the held command, the free list state and the link read
// for it, form the table write, the next head and count, and the result.
// ----------------------------------------------------------------------------
module fcba_exec (
	input  fcba_pkg::cmd_t    cmd,
	input  fcba_pkg::blk_t    block,
	input  fcba_pkg::blk_t    link_to,
	input  fcba_pkg::addr_t   head,
	input  fcba_pkg::cnt_t    count,
	input  fcba_pkg::blk_t    link,
	output fcba_pkg::wr_req_t wr,
	output fcba_pkg::addr_t   head_nxt,
	output fcba_pkg::cnt_t    count_nxt,
	output fcba_pkg::result_t res
);

	logic blk_ok;
	logic dst_ok;
	logic empty;
	logic full;

	assign blk_ok = fcba_pkg::in_range(block);
	assign dst_ok = fcba_pkg::in_range(link_to);
	assign empty  = (count == '0);
	assign full   = (count >= fcba_pkg::cnt_t'(fcba_pkg::NUM_BLOCKS));

	// Decode the command
	always_comb begin
		wr                = '0;
		head_nxt          = head;
		count_nxt         = count;
		res.status        = fcba_pkg::ST_OK;
		res.block_out     = '0;
		res.end_of_chain  = 1'b0;
		unique case (cmd)
			fcba_pkg::CMD_ALLOC: begin
				// Pop the head and make it a chain end
				if (empty) begin
					res.status = fcba_pkg::ST_EMPTY;
				end else begin
					wr.en         = 1'b1;
					wr.addr       = head;
					wr.data       = fcba_pkg::blk_t'(head);
					head_nxt      = fcba_pkg::addr_t'(link);
					count_nxt     = count - fcba_pkg::cnt_t'(1);
					res.block_out = fcba_pkg::blk_t'(head);
				end
			end
			fcba_pkg::CMD_FREE: begin
				// Push the block on the head
				if (full) begin
					res.status = fcba_pkg::ST_FULL;
				end else if (blk_ok) begin
					wr.en     = 1'b1;
					wr.addr   = fcba_pkg::addr_t'(block);
					wr.data   = fcba_pkg::blk_t'(head);
					head_nxt  = fcba_pkg::addr_t'(block);
					count_nxt = count + fcba_pkg::cnt_t'(1);
				end
			end
			fcba_pkg::CMD_NEXT: begin
				// Report the successor, out of range acts as self link
				if (blk_ok) begin
					res.block_out    = link;
					res.end_of_chain = (link == block);
				end else begin
					res.block_out    = block;
					res.end_of_chain = 1'b1;
				end
			end
			fcba_pkg::CMD_LINK: begin
				// Write the link, an out of range target ends the chain
				if (blk_ok) begin
					wr.en   = 1'b1;
					wr.addr = fcba_pkg::addr_t'(block);
					wr.data = dst_ok ? link_to : block;
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

endmodule

@@ sim/tb_fat_chain_block_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_fat_chain_block_allocator
// Self-checking bench for the chained block allocator. Commands go in through
// the start/busy handshake. A local model of the link table, free head and
// free count predicts each result beat, and every done beat is checked field
// by field against the oldest prediction. The run has a directed part, a full
// drain and refill of the free list, and random chain traffic with noise.
// ----------------------------------------------------------------------------
module tb_fat_chain_block_allocator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned ITEM_TARGET = 1550;
	localparam int unsigned GAP_PCT     = 23;
	localparam int unsigned SETTLE_GAP  = 250;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]     status;
		fcba_pkg::blk_t blk;
		logic           eoc;
		fcba_pkg::cnt_t count;
	} cmd_result_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic [1:0]     cmd;
	fcba_pkg::blk_t block;
	fcba_pkg::blk_t link_to;
	logic           done;
	logic [1:0]     status;
	fcba_pkg::blk_t block_out;
	logic           end_of_chain;
	fcba_pkg::cnt_t free_count;

	// Allocator model
	fcba_pkg::blk_t chain_link [fcba_pkg::NUM_BLOCKS];
	fcba_pkg::blk_t head_blk;
	fcba_pkg::cnt_t free_left;

	cmd_result_t    pending_results [$];
	fcba_pkg::blk_t owned [$];
	int unsigned    n_sent;
	int unsigned    n_errors;
	int unsigned    stall_cycles;
	bit             gaps_on;

	fat_chain_block_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.block        (block),
		.link_to      (link_to),
		.done         (done),
		.status       (status),
		.block_out    (block_out),
		.end_of_chain (end_of_chain),
		.free_count   (free_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every block free, list runs 0, 1, 2 ... and the last block ends it
	function automatic void reset_model();
		for (int i = 0; i < int'(fcba_pkg::NUM_BLOCKS); i++) begin
			chain_link[i] = (i + 1 < int'(fcba_pkg::NUM_BLOCKS)) ?
				fcba_pkg::blk_t'(i + 1) : fcba_pkg::blk_t'(i);
		end
		head_blk  = '0;
		free_left = fcba_pkg::cnt_t'(fcba_pkg::NUM_BLOCKS);
	endfunction

	// Run one command on the model and return the beat it should produce
	function automatic cmd_result_t apply_command(fcba_pkg::cmd_t op, fcba_pkg::blk_t b,
			fcba_pkg::blk_t t);
		cmd_result_t r;
		logic        b_ok;
		logic        t_ok;
		r.status = fcba_pkg::ST_OK;
		r.blk    = '0;
		r.eoc    = 1'b0;
		b_ok     = int'(b) < int'(fcba_pkg::NUM_BLOCKS);
		t_ok     = int'(t) < int'(fcba_pkg::NUM_BLOCKS);
		case (op)
			fcba_pkg::CMD_ALLOC: begin
				if (free_left == 0) begin
					r.status = fcba_pkg::ST_EMPTY;
				end else begin
					r.blk           = head_blk;
					head_blk        = chain_link[r.blk];
					chain_link[r.blk] = r.blk;
					free_left--;
				end
			end
			fcba_pkg::CMD_FREE: begin
				if (int'(free_left) >= int'(fcba_pkg::NUM_BLOCKS)) begin
					r.status = fcba_pkg::ST_FULL;
				end else if (b_ok) begin
					chain_link[b] = head_blk;
					head_blk      = b;
					free_left++;
				end
			end
			fcba_pkg::CMD_NEXT: begin
				if (b_ok) begin
					r.blk = chain_link[b];
					r.eoc = (r.blk == b);
				end else begin
					r.blk = b;
					r.eoc = 1'b1;
				end
			end
			default: begin
				if (b_ok) begin
					chain_link[b] = t_ok ? t : b;
				end
			end
		endcase
		r.count = free_left;
		return r;
	endfunction

	function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			end
		end
	endfunction

	// Remove and return a random block from the ones held by the bench
	function automatic fcba_pkg::blk_t take_owned();
		int unsigned    idx;
		fcba_pkg::blk_t b;
		idx = $urandom_range(owned.size() - 1);
		b   = owned[idx];
		owned.delete(idx);
		return b;
	endfunction

	// Send one command beat, predict its result, then maybe idle a while
	task automatic issue(input fcba_pkg::cmd_t op, input fcba_pkg::blk_t b,
			input fcba_pkg::blk_t t, output cmd_result_t r);
		start   <= 1'b1;
		cmd     <= op;
		block   <= b;
		link_to <= t;
		do @(posedge clk); while (busy);
		r = apply_command(op, b, t);
		pending_results = {pending_results, r};
		n_sent++;
		if (gaps_on && $urandom_range(99) < GAP_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Hold off commands until every predicted beat has come back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Corner cases: full list, chain ends, extreme links, double free
	task automatic test_directed();
		cmd_result_t    r;
		fcba_pkg::blk_t a;
		fcba_pkg::blk_t b;
		fcba_pkg::blk_t c;
		fcba_pkg::blk_t h;
		issue(fcba_pkg::CMD_FREE, 8'd0, 8'd255, r);
		issue(fcba_pkg::CMD_FREE, 8'd255, 8'd0, r);
		issue(fcba_pkg::CMD_NEXT, 8'd255, 8'd17, r);
		issue(fcba_pkg::CMD_NEXT, 8'd0, 8'd255, r);
		issue(fcba_pkg::CMD_NEXT, 8'd128, 8'd85, r);
		issue(fcba_pkg::CMD_ALLOC, 8'd255, 8'd255, r);
		a = r.blk;
		issue(fcba_pkg::CMD_ALLOC, 8'd0, 8'd0, r);
		b = r.blk;
		issue(fcba_pkg::CMD_ALLOC, 8'd170, 8'd85, r);
		c = r.blk;
		issue(fcba_pkg::CMD_NEXT, a, 8'd0, r);
		issue(fcba_pkg::CMD_LINK, a, b, r);
		issue(fcba_pkg::CMD_LINK, b, 8'd255, r);
		issue(fcba_pkg::CMD_NEXT, a, 8'd0, r);
		issue(fcba_pkg::CMD_NEXT, b, 8'd0, r);
		issue(fcba_pkg::CMD_LINK, b, 8'd0, r);
		issue(fcba_pkg::CMD_NEXT, b, 8'd255, r);
		issue(fcba_pkg::CMD_LINK, b, b, r);
		issue(fcba_pkg::CMD_NEXT, b, 8'd255, r);
		// push c twice: the second push makes it point to itself
		h = head_blk;
		issue(fcba_pkg::CMD_FREE, c, 8'd0, r);
		issue(fcba_pkg::CMD_FREE, c, 8'd0, r);
		issue(fcba_pkg::CMD_LINK, c, h, r);
		issue(fcba_pkg::CMD_FREE, a, 8'd0, r);
		issue(fcba_pkg::CMD_FREE, b, 8'd0, r);
		settle();
	endtask

	// Allocate back to back until empty, then free everything until full
	task automatic test_drain_and_fill();
		cmd_result_t r;
		gaps_on = 1'b0;
		owned.delete();
		while (free_left != 0) begin
			issue(fcba_pkg::CMD_ALLOC, fcba_pkg::blk_t'($urandom),
				fcba_pkg::blk_t'($urandom), r);
			owned = {owned, r.blk};
		end
		repeat (2) issue(fcba_pkg::CMD_ALLOC, fcba_pkg::blk_t'($urandom),
			fcba_pkg::blk_t'($urandom), r);
		while (int'(free_left) < int'(fcba_pkg::NUM_BLOCKS)) begin
			if (owned.size() != 0) begin
				issue(fcba_pkg::CMD_FREE, take_owned(), fcba_pkg::blk_t'($urandom), r);
			end else begin
				issue(fcba_pkg::CMD_FREE, fcba_pkg::blk_t'($urandom),
					fcba_pkg::blk_t'($urandom), r);
			end
		end
		issue(fcba_pkg::CMD_FREE, fcba_pkg::blk_t'($urandom),
			fcba_pkg::blk_t'($urandom), r);
		gaps_on = 1'b1;
		settle();
	endtask

	// Build, walk and release chains, mixed with stray lookups, links and frees
	task automatic test_random_traffic();
		cmd_result_t    r;
		fcba_pkg::blk_t chain [$];
		int unsigned    pick;
		int unsigned    next_settle;
		next_settle = n_sent + SETTLE_GAP;
		while (n_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				chain.delete();
				repeat ($urandom_range(1, 6)) begin
					issue(fcba_pkg::CMD_ALLOC, fcba_pkg::blk_t'($urandom),
						fcba_pkg::blk_t'($urandom), r);
					if (r.status == fcba_pkg::ST_OK) chain = {chain, r.blk};
				end
				// link each block to the next, the last one to itself
				foreach (chain[i]) begin
					issue(fcba_pkg::CMD_LINK, chain[i],
						(i + 1 < chain.size()) ? chain[i + 1] : chain[i], r);
				end
				foreach (chain[i]) begin
					issue(fcba_pkg::CMD_NEXT, chain[i], fcba_pkg::blk_t'($urandom), r);
				end
				if ($urandom_range(1) == 1) begin
					foreach (chain[i]) begin
						issue(fcba_pkg::CMD_FREE, chain[i], fcba_pkg::blk_t'($urandom), r);
					end
				end else begin
					owned = {owned, chain};
				end
			end else if (pick < 70) begin
				if (owned.size() != 0) begin
					issue(fcba_pkg::CMD_FREE, take_owned(), fcba_pkg::blk_t'($urandom), r);
				end else begin
					issue(fcba_pkg::CMD_ALLOC, fcba_pkg::blk_t'($urandom),
						fcba_pkg::blk_t'($urandom), r);
				end
			end else if (pick < 85) begin
				issue(fcba_pkg::CMD_NEXT, fcba_pkg::blk_t'($urandom),
					fcba_pkg::blk_t'($urandom), r);
			end else if (pick < 95 && owned.size() != 0) begin
				issue(fcba_pkg::CMD_LINK, owned[$urandom_range(owned.size() - 1)],
					fcba_pkg::blk_t'($urandom), r);
			end else if (pick < 98) begin
				issue(fcba_pkg::CMD_LINK, fcba_pkg::blk_t'($urandom),
					fcba_pkg::blk_t'($urandom), r);
			end else begin
				issue(fcba_pkg::CMD_FREE, fcba_pkg::blk_t'($urandom),
					fcba_pkg::blk_t'($urandom), r);
			end
			if (n_sent >= next_settle) begin
				settle();
				next_settle = n_sent + SETTLE_GAP;
			end
		end
		settle();
	endtask

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin : check_beat
		cmd_result_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("%0t: result beat with nothing expected", $time);
				end
			end else begin
				want = pending_results.pop_front();
				check_field("status", 9'(want.status), 9'(status));
				check_field("block_out", 9'(want.blk), 9'(block_out));
				check_field("end_of_chain", 9'(want.eoc), 9'(end_of_chain));
				check_field("free_count", want.count, free_count);
			end
		end
	end

	// Stop the run when no beat moves for too long
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		start    <= 1'b0;
		cmd      <= fcba_pkg::CMD_ALLOC;
		block    <= '0;
		link_to  <= '0;
		n_sent   = 0;
		n_errors = 0;
		stall_cycles = 0;
		gaps_on  = 1'b1;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_and_fill();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/fcba_pkg.sv
rtl/core/fcba_link_mem.sv
rtl/core/fcba_exec.sv
rtl/core/fat_chain_block_allocator.sv
sim/tb_fat_chain_block_allocator.sv
